// ===== hdl/ipf_pkg.sv =====
package ipf_pkg;

  localparam int unsigned ListEntries = 256;
  localparam int unsigned SlotW = 8;

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeIpv6 = 16'h86DD;
  localparam logic [15:0] LenEth = 16'd14;
  localparam logic [15:0] LenIpv4 = 16'd34;
  localparam logic [15:0] LenIpv6 = 16'd54;
  localparam logic [31:0] Net8Mask = 32'hFF000000;
  localparam logic [31:0] LoopNet = 32'h7F000000;

  localparam logic [1:0] OpClassify = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [1:0] SelAllow4 = 2'd0;
  localparam logic [1:0] SelAllow6 = 2'd1;
  localparam logic [1:0] SelBlock4 = 2'd2;
  localparam logic [1:0] SelBlock6 = 2'd3;

  localparam logic [2:0] RsnNone = 3'd0;
  localparam logic [2:0] RsnTrunc = 3'd1;
  localparam logic [2:0] RsnLoop = 3'd2;
  localparam logic [2:0] RsnAllow = 3'd3;
  localparam logic [2:0] RsnDst = 3'd4;
  localparam logic [2:0] RsnSrc = 3'd5;
  localparam logic [2:0] RsnNoMatch = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture the input word
    logic scan_clr;  // restart slot counter, select a list and key
    logic [1:0] list; // list scanned (SelXxx)
    logic use_src;   // compare against source when 1
    logic step;      // advance slot counter
    logic hit_rd;    // issue hit read at matched or requested slot
    logic hit_wr;    // write back incremented hits
    logic done;      // drive result
  } ipf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic [2:0] early;   // reason decided without a scan, RsnNone if scans needed
    logic       is_ip;   // IPv4 or IPv6 ether type
    logic       is_v6;
    logic       match;   // current entry matches (compare of registered read data)
    logic       last;    // compare of last slot is in match
  } ipf_sts_t;

endpackage

// ===== hdl/ipf_datapath.sv =====
module ipf_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            operation_i,
  input  logic [15:0]           frame_length_i,
  input  logic [15:0]           ether_type_i,
  input  logic [63:0]           source_high_i,
  input  logic [63:0]           source_low_i,
  input  logic [63:0]           dest_high_i,
  input  logic [63:0]           dest_low_i,
  input  logic [1:0]            list_select_i,
  input  logic [7:0]            slot_i,
  input  logic                  entry_valid_i,
  input  ipf_pkg::ipf_cmd_t     cmd_i,
  input  logic [2:0]            reason_i,
  output ipf_pkg::ipf_sts_t     sts_o,
  output logic                  done_o,
  output logic                  verdict_o,
  output logic [2:0]            reason_o,
  output logic [7:0]            matched_slot_o,
  output logic [63:0]           entry_hits_o,
  output logic [63:0]           total_frames_o,
  output logic [63:0]           dropped_frames_o
);
  import ipf_pkg::*;

  logic [1:0]  op_q;
  logic [15:0] len_q, et_q;
  logic [63:0] sh_q, sl_q, dh_q, dl_q;
  logic [1:0]  sel_q;
  logic [7:0]  slot_q;

  logic [31:0] a4_key [ListEntries];
  logic [63:0] a6_kh [ListEntries];
  logic [63:0] a6_kl [ListEntries];
  logic [31:0] b4_key [ListEntries];
  logic [63:0] b6_kh [ListEntries];
  logic [63:0] b6_kl [ListEntries];
  logic [63:0] b4_hits [ListEntries];
  logic [63:0] b6_hits [ListEntries];
  logic [ListEntries-1:0] a4_v_q, a6_v_q, b4_v_q, b6_v_q;

  logic [SlotW-1:0] idx_q, mslot_q;
  logic [SlotW:0]   cnt_q;
  logic [1:0]       list_q;
  logic             src_q, cmp_vld_q;
  logic [31:0]      rd4_q;
  logic [63:0]      rdh_q, rdl_q;
  logic             rdv_q, rdlast_q;
  logic [63:0]      hit_rd_q, hits_q;
  logic             rd_blk6_q;
  logic [63:0]      seen_q, drop_q;
  logic             done_q, verdict_q;
  logic [2:0]       reason_q;
  logic [7:0]       oslot_q;

  logic [31:0] sa4, da4;
  logic        wr_en;
  logic [SlotW-1:0] widx, ridx;
  logic [63:0] kh, kl;
  logic        match;

  assign sa4 = sl_q[31:0];
  assign da4 = dl_q[31:0];
  assign wr_en = cmd_i.latch && operation_i == OpWrite;
  assign widx = slot_i[SlotW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= operation_i; len_q <= frame_length_i; et_q <= ether_type_i;
      sh_q <= source_high_i; sl_q <= source_low_i;
      dh_q <= dest_high_i; dl_q <= dest_low_i;
      sel_q <= list_select_i; slot_q <= slot_i;
    end
  end

  // list key memories: written on a valid write word, read one slot per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en && entry_valid_i) begin
      case (list_select_i)
        SelAllow4: a4_key[widx] <= source_low_i[31:0];
        SelAllow6: begin
          a6_kh[widx] <= source_high_i; a6_kl[widx] <= source_low_i;
        end
        SelBlock4: b4_key[widx] <= source_low_i[31:0];
        SelBlock6: begin
          b6_kh[widx] <= source_high_i; b6_kl[widx] <= source_low_i;
        end
        default: ;
      endcase
    end
    case (list_q)
      SelAllow4: rd4_q <= a4_key[idx_q];
      SelBlock4: rd4_q <= b4_key[idx_q];
      default:   rd4_q <= b4_key[idx_q];
    endcase
    case (list_q)
      SelAllow6: begin rdh_q <= a6_kh[idx_q]; rdl_q <= a6_kl[idx_q]; end
      default:   begin rdh_q <= b6_kh[idx_q]; rdl_q <= b6_kl[idx_q]; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a4_v_q <= '0; a6_v_q <= '0; b4_v_q <= '0; b6_v_q <= '0;
    end else if (wr_en) begin
      case (list_select_i)
        SelAllow4: a4_v_q[widx] <= entry_valid_i;
        SelAllow6: a6_v_q[widx] <= entry_valid_i;
        SelBlock4: b4_v_q[widx] <= entry_valid_i;
        SelBlock6: b6_v_q[widx] <= entry_valid_i;
        default: ;
      endcase
    end
  end

  // scan counter: idx is address, compare in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; cnt_q <= '0; list_q <= SelAllow4; src_q <= 1'b0;
      cmp_vld_q <= 1'b0; rdv_q <= 1'b0; rdlast_q <= 1'b0; mslot_q <= '0;
    end else begin
      if (cmd_i.scan_clr) begin
        idx_q <= '0; cnt_q <= '0; list_q <= cmd_i.list; src_q <= cmd_i.use_src;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.step) begin
        cmp_vld_q <= 1'b1;
        mslot_q <= idx_q;
        rdlast_q <= cnt_q == (SlotW+1)'(ListEntries - 1);
        case (list_q)
          SelAllow4: rdv_q <= a4_v_q[idx_q];
          SelAllow6: rdv_q <= a6_v_q[idx_q];
          SelBlock4: rdv_q <= b4_v_q[idx_q];
          default:   rdv_q <= b6_v_q[idx_q];
        endcase
        idx_q <= idx_q + 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    kh = src_q ? sh_q : dh_q;
    kl = src_q ? sl_q : dl_q;
    if (list_q == SelAllow4 || list_q == SelBlock4)
      match = cmp_vld_q && rdv_q && rd4_q == kl[31:0];
    else
      match = cmp_vld_q && rdv_q && rdh_q == kh && rdl_q == kl;
  end

  always_comb begin
    sts_o.op = op_q;
    sts_o.is_ip = et_q == EtypeIpv4 || et_q == EtypeIpv6;
    sts_o.is_v6 = et_q == EtypeIpv6;
    sts_o.match = match;
    sts_o.last = cmp_vld_q && rdlast_q;
    sts_o.early = RsnNone;
    if (len_q < LenEth) sts_o.early = RsnTrunc;
    else if (et_q == EtypeIpv4) begin
      if (len_q < LenIpv4) sts_o.early = RsnTrunc;
      else if ((sa4 & Net8Mask) == LoopNet || (da4 & Net8Mask) == LoopNet)
        sts_o.early = RsnLoop;
    end else if (et_q == EtypeIpv6) begin
      if (len_q < LenIpv6) sts_o.early = RsnTrunc;
      else if (sh_q == 64'd0 && sl_q == 64'd1) sts_o.early = RsnLoop;
    end else sts_o.early = RsnNone;
  end

  // hit counters: read at hit_rd (matched slot or sw slot), write back +1
  logic [SlotW-1:0] hslot;
  logic             hv6;
  assign ridx = (op_q == OpRead) ? slot_q[SlotW-1:0] : mslot_q;
  assign hv6 = (op_q == OpRead) ? (sel_q == SelBlock6) : (list_q == SelBlock6);
  assign hslot = ridx;

  always_ff @(posedge clk_i) begin
    if (wr_en && entry_valid_i && list_select_i == SelBlock4) b4_hits[widx] <= '0;
    else if (cmd_i.hit_wr && !rd_blk6_q) b4_hits[hslot] <= hit_rd_q + 64'd1;
    if (wr_en && entry_valid_i && list_select_i == SelBlock6) b6_hits[widx] <= '0;
    else if (cmd_i.hit_wr && rd_blk6_q) b6_hits[hslot] <= hit_rd_q + 64'd1;
    if (cmd_i.hit_rd) begin
      hit_rd_q <= hv6 ? b6_hits[hslot] : b4_hits[hslot];
      rd_blk6_q <= hv6;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0; drop_q <= '0; done_q <= 1'b0; verdict_q <= 1'b0;
      reason_q <= RsnNone; oslot_q <= '0; hits_q <= '0;
    end else begin
      done_q <= cmd_i.done;
      if (cmd_i.done) begin
        verdict_q <= 1'b0; reason_q <= RsnNone; oslot_q <= '0; hits_q <= '0;
        if (op_q == OpClassify) begin
          seen_q <= seen_q + 64'd1;
          reason_q <= reason_i;
          if (reason_i == RsnDst || reason_i == RsnSrc) begin
            verdict_q <= 1'b1;
            oslot_q <= 8'(mslot_q);
            hits_q <= hit_rd_q + 64'd1;
            drop_q <= drop_q + 64'd1;
          end
        end else if (op_q == OpRead && (sel_q == SelBlock4 || sel_q == SelBlock6)) begin
          hits_q <= hit_rd_q;
        end
      end
    end
  end

  assign done_o = done_q;
  assign verdict_o = verdict_q;
  assign reason_o = reason_q;
  assign matched_slot_o = oslot_q;
  assign entry_hits_o = hits_q;
  assign total_frames_o = seen_q;
  assign dropped_frames_o = drop_q;
endmodule

// ===== hdl/ipf_ctrl.sv =====
module ipf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ipf_pkg::ipf_sts_t sts_i,
  output ipf_pkg::ipf_cmd_t cmd_o,
  output logic [2:0]        reason_o,
  output logic              busy_o
);
  import ipf_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StDec   = 7'b0000010,
    StClr   = 7'b0000100,
    StScan  = 7'b0001000,
    StHitRd = 7'b0010000,
    StHitWr = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] phase_q, phase_d; // 0 allow dst,1 allow src,2 block dst,3 block src
  logic [2:0] rsn_q, rsn_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; phase_q <= 2'd0; rsn_q <= RsnNone;
    end else begin
      state_q <= state_d; phase_q <= phase_d; rsn_q <= rsn_d;
    end
  end

  always_comb begin
    state_d = state_q; phase_d = phase_q; rsn_d = rsn_q;
    cmd_o = '0;
    cmd_o.list = sts_i.is_v6 ? (phase_q[1] ? SelBlock6 : SelAllow6)
                             : (phase_q[1] ? SelBlock4 : SelAllow4);
    cmd_o.use_src = phase_q[0];
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d = StDec;
        end
      end
      StDec: begin
        phase_d = 2'd0;
        rsn_d = RsnNone;
        if (sts_i.op == OpRead) state_d = StHitRd;
        else if (sts_i.op != OpClassify) state_d = StDone;
        else if (sts_i.early != RsnNone) begin
          rsn_d = sts_i.early; state_d = StDone;
        end else if (!sts_i.is_ip) state_d = StDone;
        else state_d = StClr;
      end
      StClr: begin
        cmd_o.scan_clr = 1'b1;
        state_d = StScan;
      end
      StScan: begin
        cmd_o.step = 1'b1;
        if (sts_i.match) begin
          cmd_o.step = 1'b0;
          case (phase_q)
            2'd0, 2'd1: begin rsn_d = RsnAllow; state_d = StDone; end
            2'd2: begin rsn_d = RsnDst; state_d = StHitRd; end
            default: begin rsn_d = RsnSrc; state_d = StHitRd; end
          endcase
        end else if (sts_i.last) begin
          cmd_o.step = 1'b0;
          if (phase_q == 2'd3) begin
            rsn_d = RsnNoMatch; state_d = StDone;
          end else begin
            phase_d = phase_q + 2'd1; state_d = StClr;
          end
        end
      end
      StHitRd: begin
        cmd_o.hit_rd = 1'b1;
        state_d = (sts_i.op == OpClassify) ? StHitWr : StDone;
      end
      StHitWr: begin
        cmd_o.hit_wr = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        cmd_o.done = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign reason_o = (sts_i.op == OpClassify && sts_i.early == RsnNone
                     && (rsn_q == RsnNone)) ? RsnNone : rsn_q;
  assign busy_o = state_q != StIdle;
endmodule

// ===== hdl/ip_allow_block_packet_filter.sv =====
// Frame filter with allow and block lists of 256 slots per family. A word
// (classify, slot write, hit read) is taken when start is high and busy is
// low; exactly one result follows, valid for one cycle with done_o high, and
// must be captured then: the receiver cannot stall it. Writes, unused
// operations and classifies that need no lookup (non-IP, truncated, loopback)
// go from decode straight to the done state, reads through a hit read state;
// done_o is registered from the done state. A classify that needs lookups
// scans the allow list for destination and source, then the block list, one
// slot per cycle through the key memory read port; a drop adds a hit read and
// write back, and an early hit ends the scan. The next word can be taken at
// the edge that closes the done_o cycle. Stale keys of cleared slots stay in
// memory but never match.
module ip_allow_block_packet_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [15:0] frame_length_i,
  input  logic [15:0] ether_type_i,
  input  logic [63:0] source_high_i,
  input  logic [63:0] source_low_i,
  input  logic [63:0] dest_high_i,
  input  logic [63:0] dest_low_i,
  input  logic [1:0]  list_select_i,
  input  logic [7:0]  slot_i,
  input  logic        entry_valid_i,
  output logic        done_o,
  output logic        verdict_o,
  output logic [2:0]  reason_o,
  output logic [7:0]  matched_slot_o,
  output logic [63:0] entry_hits_o,
  output logic [63:0] total_frames_o,
  output logic [63:0] dropped_frames_o
);
  import ipf_pkg::*;

  ipf_cmd_t   cmd;
  ipf_sts_t   sts;
  logic [2:0] rsn;

  ipf_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .cmd_o(cmd),
    .reason_o(rsn), .busy_o(busy)
  );

  ipf_datapath u_dp (
    .clk_i, .rst_ni, .operation_i, .frame_length_i, .ether_type_i,
    .source_high_i, .source_low_i, .dest_high_i, .dest_low_i,
    .list_select_i, .slot_i, .entry_valid_i, .cmd_i(cmd), .reason_i(rsn),
    .sts_o(sts), .done_o, .verdict_o, .reason_o, .matched_slot_o,
    .entry_hits_o, .total_frames_o, .dropped_frames_o
  );
endmodule

// ===== hdl/ipf_checker.sv =====
module ipf_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        verdict_o,
  input logic [2:0]  reason_o,
  input logic [7:0]  matched_slot_o,
  input logic [63:0] dropped_frames_o
);
  import ipf_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept without busy");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");

  a_drop_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && verdict_o |-> reason_o == RsnDst || reason_o == RsnSrc)
    else $error("drop with wrong reason");

  a_drop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && verdict_o |-> dropped_frames_o != $past(dropped_frames_o))
    else $error("drop not counted");

  a_pass_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !verdict_o |-> matched_slot_o == 8'd0)
    else $error("slot on a pass");
endmodule

bind ip_allow_block_packet_filter ipf_props u_props (
  .clk_i, .rst_ni, .start, .busy, .done_o, .verdict_o, .reason_o,
  .matched_slot_o, .dropped_frames_o
);

// ===== bench/ipf_checker.sv =====
`timescale 1ns / 1ps

module ipf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [15:0] frame_length_i,
  input  logic [15:0] ether_type_i,
  input  logic [63:0] source_high_i,
  input  logic [63:0] source_low_i,
  input  logic [63:0] dest_high_i,
  input  logic [63:0] dest_low_i,
  input  logic [1:0]  list_select_i,
  input  logic [7:0]  slot_i,
  input  logic        entry_valid_i,
  input  logic        done_o,
  input  logic        verdict_o,
  input  logic [2:0]  reason_o,
  input  logic [7:0]  matched_slot_o,
  input  logic [63:0] entry_hits_o,
  input  logic [63:0] total_frames_o,
  input  logic [63:0] dropped_frames_o,
  output int          errors_o,
  output int          pending_o
);
  import ipf_pkg::*;

  typedef struct packed {
    logic        verdict;
    logic [2:0]  reason;
    logic [7:0]  mslot;
    logic [63:0] hits;
    logic [63:0] total;
    logic [63:0] dropped;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [63:0] key_hi [4][ListEntries];
  logic [63:0] key_lo [4][ListEntries];
  bit          key_ok [4][ListEntries];
  logic [63:0] hit_cnt[4][ListEntries];
  logic [63:0] frames_seen, frames_dropped;
  int          err_cnt;

  assign errors_o  = err_cnt;
  assign pending_o = verdict_q.size();

  // lowest valid slot holding the key, -1 if none
  function automatic int lookup(input logic [1:0] sel, input logic [63:0] kh, kl);
    for (int i = 0; i < ListEntries; i++) begin
      if (key_ok[sel][i] && key_lo[sel][i] == kl &&
          (sel == SelAllow4 || sel == SelBlock4 || key_hi[sel][i] == kh)) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic verdict_t filter_word();
    verdict_t r;
    int m;
    logic [63:0] sa, da, sh, dh;
    logic [1:0] al, bl;
    r = '0;
    m = -1;
    if (operation_i == OpClassify) begin
      frames_seen++;
      if (ether_type_i == EtypeIpv4) begin
        sa = {32'd0, source_low_i[31:0]};
        da = {32'd0, dest_low_i[31:0]};
        sh = '0;
        dh = '0;
        al = SelAllow4;
        bl = SelBlock4;
      end else begin
        sa = source_low_i;
        da = dest_low_i;
        sh = source_high_i;
        dh = dest_high_i;
        al = SelAllow6;
        bl = SelBlock6;
      end
      if (frame_length_i < LenEth) begin
        r.reason = RsnTrunc;
      end else if (ether_type_i != EtypeIpv4 && ether_type_i != EtypeIpv6) begin
        r.reason = RsnNone;
      end else if ((ether_type_i == EtypeIpv4 && frame_length_i < LenIpv4) ||
                   (ether_type_i == EtypeIpv6 && frame_length_i < LenIpv6)) begin
        r.reason = RsnTrunc;
      end else if ((ether_type_i == EtypeIpv4 && ((sa[31:0] & Net8Mask) == LoopNet ||
                    (da[31:0] & Net8Mask) == LoopNet)) ||
                   (ether_type_i == EtypeIpv6 && sh == 0 && sa == 1)) begin
        r.reason = RsnLoop;
      end else if (lookup(al, dh, da) >= 0 || lookup(al, sh, sa) >= 0) begin
        r.reason = RsnAllow;
      end else if ((m = lookup(bl, dh, da)) >= 0) begin
        r.reason = RsnDst;
      end else if ((m = lookup(bl, sh, sa)) >= 0) begin
        r.reason = RsnSrc;
      end else begin
        r.reason = RsnNoMatch;
      end
      if (m >= 0) begin
        hit_cnt[bl][m]++;
        r.hits = hit_cnt[bl][m];
        r.verdict = 1'b1;
        r.mslot = m[7:0];
        frames_dropped++;
      end
    end else if (operation_i == OpWrite) begin
      if (entry_valid_i) begin
        key_hi[list_select_i][slot_i] = source_high_i;
        key_lo[list_select_i][slot_i] = (list_select_i == SelAllow4 ||
            list_select_i == SelBlock4) ? {32'd0, source_low_i[31:0]} : source_low_i;
        hit_cnt[list_select_i][slot_i] = '0;
      end
      key_ok[list_select_i][slot_i] = entry_valid_i;
    end else if (operation_i == OpRead) begin
      if (list_select_i == SelBlock4 || list_select_i == SelBlock6) begin
        r.hits = hit_cnt[list_select_i][slot_i];
      end
    end
    r.total = frames_seen;
    r.dropped = frames_dropped;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t e;
    if (!rst_ni) begin
      for (int l = 0; l < 4; l++) begin
        for (int i = 0; i < ListEntries; i++) begin
          key_ok[l][i] = 1'b0;
          hit_cnt[l][i] = '0;
        end
      end
      frames_seen = '0;
      frames_dropped = '0;
      err_cnt = 0;
      verdict_q.delete();
    end else begin
      if (done_o) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with nothing expected, reason %0d", $time, reason_o);
          err_cnt++;
        end else begin
          e = verdict_q.pop_front();
          if (verdict_o !== e.verdict) begin
            $display("%0t: verdict exp %0d got %0d", $time, e.verdict, verdict_o);
            err_cnt++;
          end
          if (reason_o !== e.reason) begin
            $display("%0t: reason exp %0d got %0d", $time, e.reason, reason_o);
            err_cnt++;
          end
          if (matched_slot_o !== e.mslot) begin
            $display("%0t: slot exp %0d got %0d", $time, e.mslot, matched_slot_o);
            err_cnt++;
          end
          if (entry_hits_o !== e.hits) begin
            $display("%0t: hits exp %h got %h", $time, e.hits, entry_hits_o);
            err_cnt++;
          end
          if (total_frames_o !== e.total) begin
            $display("%0t: total exp %h got %h", $time, e.total, total_frames_o);
            err_cnt++;
          end
          if (dropped_frames_o !== e.dropped) begin
            $display("%0t: dropped exp %h got %h", $time, e.dropped, dropped_frames_o);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        verdict_q.push_back(filter_word());
      end
    end
  end

endmodule

// ===== bench/tb_ip_allow_block_packet_filter.sv =====
`timescale 1ns / 1ps

module tb_ip_allow_block_packet_filter;
  import ipf_pkg::*;

  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = OpRead;
  logic [15:0] frame_length_i = '0;
  logic [15:0] ether_type_i = '0;
  logic [63:0] source_high_i = '0;
  logic [63:0] source_low_i = '0;
  logic [63:0] dest_high_i = '0;
  logic [63:0] dest_low_i = '0;
  logic [1:0]  list_select_i = SelAllow4;
  logic [7:0]  slot_i = '0;
  logic        entry_valid_i = 1'b0;
  logic        done_o, verdict_o;
  logic [2:0]  reason_o;
  logic [7:0]  matched_slot_o;
  logic [63:0] entry_hits_o, total_frames_o, dropped_frames_o;
  int          errors, pending, idle_cycles;

  logic [31:0] v4_pool[16];
  logic [63:0] v6_hi_pool[16], v6_lo_pool[16];
  bit          installed[4][ListEntries];

  ip_allow_block_packet_filter dut (.*);

  ipf_checker u_checker (.*, .errors_o(errors), .pending_o(pending));

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // sends one word; returns right after the edge that took it
  task automatic send(input logic [1:0] op, input logic [15:0] len, etype,
                      input logic [63:0] sh, sl, dh, dl, input logic [1:0] sel,
                      input logic [7:0] slot, input logic vld);
    start <= 1'b1;
    operation_i <= op;
    frame_length_i <= len;
    ether_type_i <= etype;
    source_high_i <= sh;
    source_low_i <= sl;
    dest_high_i <= dh;
    dest_low_i <= dl;
    list_select_i <= sel;
    slot_i <= slot;
    entry_valid_i <= vld;
    if (op == OpWrite && vld) installed[sel][slot] = 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(20, 200);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic write_slot(input logic [1:0] sel, input logic [7:0] slot,
                            input logic [63:0] kh, kl, input logic vld);
    send(OpWrite, 16'($urandom), 16'($urandom), kh, kl, rnd64(), rnd64(), sel, slot, vld);
    gap();
  endtask

  task automatic frame(input logic [15:0] len, etype, input logic [63:0] sh, sl, dh, dl);
    send(OpClassify, len, etype, sh, sl, dh, dl, 2'($urandom), 8'($urandom),
         1'($urandom));
    gap();
  endtask

  task automatic read_slot(input logic [1:0] sel, input logic [7:0] slot);
    send(OpRead, 16'($urandom), 16'($urandom), rnd64(), rnd64(), rnd64(), rnd64(), sel,
         slot, 1'($urandom));
    gap();
  endtask

  function automatic logic [63:0] pick_v4();
    logic [63:0] a;
    a = rnd64();
    if ($urandom_range(0, 99) < 75) a[31:0] = v4_pool[$urandom_range(0, 15)];
    if ($urandom_range(0, 99) < 4) a[31:24] = 8'h7F;
    return a;
  endfunction

  task automatic pick_v6(output logic [63:0] h, l);
    int k;
    h = rnd64();
    l = rnd64();
    if ($urandom_range(0, 99) < 75) begin
      k = $urandom_range(0, 15);
      h = v6_hi_pool[k];
      l = v6_lo_pool[k];
    end
  endtask

  initial begin
    logic [63:0] sh, sl, dh, dl;
    logic [15:0] len, et;
    logic [1:0] sel;
    logic [7:0] slot;
    int r;
    for (int i = 0; i < 16; i++) begin
      v4_pool[i] = $urandom;
      if (v4_pool[i][31:24] == 8'h7F) v4_pool[i][31] = 1'b0;
      v6_hi_pool[i] = rnd64();
      v6_lo_pool[i] = rnd64();
    end
    v4_pool[0] = 32'hFFFF_FFFF;
    v4_pool[1] = 32'h0000_0000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    write_slot(SelAllow4, 8'd0, rnd64(), {32'hFFFF_FFFF, v4_pool[2]}, 1'b1);
    write_slot(SelAllow6, 8'd255, v6_hi_pool[2], v6_lo_pool[2], 1'b1);
    write_slot(SelBlock4, 8'd0, '0, {32'd0, v4_pool[0]}, 1'b1);
    write_slot(SelBlock4, 8'd1, '0, {32'd0, v4_pool[0]}, 1'b1);
    write_slot(SelBlock4, 8'd255, '0, {32'd0, v4_pool[1]}, 1'b1);
    write_slot(SelBlock6, 8'd255, v6_hi_pool[3], v6_lo_pool[3], 1'b1);
    frame(16'd0, EtypeIpv4, '0, '0, '0, '0);
    frame(16'd13, EtypeIpv6, '0, '0, '0, '0);
    frame(16'hFFFF, 16'hFFFF, '1, '1, '1, '1);
    frame(16'd33, EtypeIpv4, '0, {32'd0, v4_pool[0]}, '0, {32'd0, v4_pool[0]});
    frame(16'd53, EtypeIpv6, '0, v6_lo_pool[3], '0, v6_lo_pool[3]);
    frame(16'd34, EtypeIpv4, '0, 64'h7F00_0001, '0, {32'd0, v4_pool[0]});
    frame(16'd34, EtypeIpv4, '0, {32'd0, v4_pool[0]}, '0, 64'h7FFF_FFFF);
    frame(16'd54, EtypeIpv6, '0, 64'd1, v6_hi_pool[3], v6_lo_pool[3]);
    frame(16'd1500, EtypeIpv4, '1, {32'd0, v4_pool[0]}, '1, {32'd0, v4_pool[2]});
    frame(16'd1500, EtypeIpv4, '0, {32'd0, v4_pool[2]}, '0, {32'd0, v4_pool[0]});
    frame(16'd1500, EtypeIpv4, '0, {32'd0, v4_pool[1]}, '0, {32'd0, v4_pool[0]});
    frame(16'd1500, EtypeIpv4, '0, {32'd0, v4_pool[0]}, '0, {32'd0, v4_pool[1]});
    frame(16'd1500, EtypeIpv4, '0, {32'd0, v4_pool[5]}, '0, {32'd0, v4_pool[6]});
    frame(16'd1500, EtypeIpv6, v6_hi_pool[3], v6_lo_pool[3], '1, '1);
    frame(16'd1500, EtypeIpv6, v6_hi_pool[2], v6_lo_pool[2], v6_hi_pool[3], v6_lo_pool[3]);
    read_slot(SelBlock4, 8'd0);
    read_slot(SelAllow6, 8'd255);
    write_slot(SelBlock4, 8'd0, '0, '0, 1'b0);
    frame(16'd1500, EtypeIpv4, '0, {32'd0, v4_pool[0]}, '0, {32'd0, v4_pool[0]});
    read_slot(SelBlock4, 8'd0);
    send(OpUnused, 16'($urandom), 16'($urandom), rnd64(), rnd64(), rnd64(), rnd64(),
         SelBlock6, 8'd7, 1'b1);
    gap();

    // random part
    for (int n = 0; n < 1150; n++) begin
      r = $urandom_range(0, 99);
      sel = 2'($urandom);
      slot = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      if (r < 60) begin
        r = $urandom_range(0, 99);
        et = (r < 45) ? EtypeIpv4 : (r < 90) ? EtypeIpv6 : 16'($urandom);
        r = $urandom_range(0, 99);
        len = (r < 85) ? 16'($urandom_range(54, 1600)) :
              (r < 92) ? 16'($urandom_range(0, 55)) : 16'($urandom);
        if (et == EtypeIpv6) begin
          pick_v6(sh, sl);
          pick_v6(dh, dl);
          if ($urandom_range(0, 99) < 4) begin
            sh = '0;
            sl = 64'd1;
          end
        end else begin
          sh = rnd64();
          dh = rnd64();
          sl = pick_v4();
          dl = pick_v4();
        end
        frame(len, et, sh, sl, dh, dl);
      end else if (r < 85) begin
        if (sel == SelAllow4 || sel == SelBlock4) begin
          sh = rnd64();
          sl = pick_v4();
        end else begin
          pick_v6(sh, sl);
        end
        write_slot(sel, slot, sh, sl, $urandom_range(0, 99) < 85);
      end else if (r < 97) begin
        if ((sel == SelBlock4 || sel == SelBlock6) && !installed[sel][slot]) sel = SelAllow4;
        read_slot(sel, slot);
      end else begin
        send(OpUnused, 16'($urandom), 16'($urandom), rnd64(), rnd64(), rnd64(), rnd64(),
             sel, slot, 1'($urandom));
        gap();
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
